@@ design/vrp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package vrp_pkg;
    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_INDEX_W-1:0] REG_COS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT= 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DOFS  = 3'd4;

    localparam logic signed [15:0] COS_RESET  = 16'sd16384;
    localparam logic signed [15:0] SIN_RESET  = 16'sd0;
    localparam logic [12:0]        WIDTH_RESET = 13'd640;
    localparam logic [12:0]        HEIGHT_RESET = 13'd480;
    localparam logic [30:0]        DOFS_RESET = 31'd5570560;

    // projection numerator |v|*H fits in 45 bits; divisor 2*depth in 33 bits
    localparam int NUM_W = 45;
    localparam int DEN_W = 33;

    typedef struct packed {
        logic signed [31:0] model_x;
        logic signed [31:0] model_y;
        logic signed [31:0] model_z;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] view_depth;
        logic               behind_viewer;
    } screen_t;

    // rotated, depth-resolved vertex handed from front to back
    typedef struct packed {
        logic signed [31:0] px;     // x2
        logic signed [31:0] py;     // -y1 (33 bit range folded below)
        logic               py_neg; // sign of -y1
        logic [31:0]        py_mag; // |y1|
        logic signed [31:0] depth;
        logic               behind;
    } rotated_t;

    typedef struct packed {
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic [12:0]        view_width;
        logic [12:0]        view_height;
        logic [30:0]        depth_offset;
    } cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

@@ design/vrp_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface vrp_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/vrp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Rotation front end: 4 stages (X rotate, Y rotate, depth, classify).
// Stalls as one unit; pipe advances when its last stage is empty or taken.
module vrp_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire vrp_pkg::cfg_t         cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire vrp_pkg::vertex_t      in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output vrp_pkg::rotated_t          out_data
);
    logic [3:0] v_reg;
    logic       adv;

    logic signed [31:0] s1_x_reg, s1_y1_reg, s1_z1_reg;
    logic signed [31:0] s2_x2_reg, s2_y1_reg, s2_z2_reg;
    logic signed [31:0] s3_x2_reg, s3_y1_reg, s3_d_reg;
    vrp_pkg::rotated_t  s4_reg;

    logic signed [48:0] y1_acc, z1_acc, x2_acc, z2_acc;
    logic signed [47:0] d_sum;
    logic signed [32:0] ny1;

    assign adv       = !v_reg[3] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[3];
    assign out_data  = s4_reg;

    always_comb
    begin
        y1_acc = 49'(in_data.model_y * cfg.cos_angle) - 49'(in_data.model_z * cfg.sin_angle)
                 + 49'sd8192;
        z1_acc = 49'(in_data.model_y * cfg.sin_angle) + 49'(in_data.model_z * cfg.cos_angle)
                 + 49'sd8192;
        x2_acc = 49'(s1_x_reg * cfg.cos_angle) + 49'(s1_z1_reg * cfg.sin_angle) + 49'sd8192;
        z2_acc = 49'(s1_z1_reg * cfg.cos_angle) - 49'(s1_x_reg * cfg.sin_angle) + 49'sd8192;
        d_sum  = 48'(s2_z2_reg) + 48'($signed({1'b0, cfg.depth_offset}));
        ny1    = -33'(s3_y1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg  <= in_data.model_x;
            s1_y1_reg <= vrp_pkg::sat32(48'(y1_acc >>> 14));
            s1_z1_reg <= vrp_pkg::sat32(48'(z1_acc >>> 14));
            s2_x2_reg <= vrp_pkg::sat32(48'(x2_acc >>> 14));
            s2_z2_reg <= vrp_pkg::sat32(48'(z2_acc >>> 14));
            s2_y1_reg <= s1_y1_reg;
            s3_x2_reg <= s2_x2_reg;
            s3_y1_reg <= s2_y1_reg;
            s3_d_reg  <= vrp_pkg::sat32(d_sum);
            s4_reg.px     <= s3_x2_reg;
            s4_reg.py     <= ny1[31:0];
            s4_reg.py_neg <= ny1[32];
            s4_reg.py_mag <= s3_y1_reg[31] ? 32'(-33'(s3_y1_reg)) : s3_y1_reg;
            s4_reg.depth  <= s3_d_reg;
            s4_reg.behind <= (s3_d_reg <= 32'sd0);
        end
    end

    a_behind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.behind |-> out_data.depth <= 32'sd0)
        else $error("behind flag disagrees with depth");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("front output changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("front stalled with empty tail");
endmodule
`default_nettype wire

@@ design/vrp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-entry queue between front and back.
module vrp_fifo #(parameter int W = 8) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         wr, rd;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= in_data;
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready)
        else $error("queue accepted while full");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("queue head changed while stalled");
endmodule
`default_nettype wire

@@ design/vrp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Projection back end: multiply by H, pipelined restoring divider (one
// quotient bit per stage, NUM_W+F stages), then sign, offset, saturate.
module vrp_back #(
    parameter int COORD_FRAC_BITS = vrp_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire vrp_pkg::cfg_t     cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire vrp_pkg::rotated_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output vrp_pkg::screen_t       out_data
);
    localparam int F     = COORD_FRAC_BITS;
    localparam int QB    = vrp_pkg::NUM_W + F; // quotient bits of num*2^F/den
    localparam int NS    = QB;                 // divider stages
    localparam int PW    = vrp_pkg::NUM_W + F;
    localparam int DW    = vrp_pkg::DEN_W;
    localparam int L     = NS + 2;

    typedef struct packed {
        logic [PW-1:0] nx;   // remaining numerator bits, shifted out MSB first
        logic [PW-1:0] ny;
        logic [DW:0]   rx;
        logic [DW:0]   ry;
        logic [PW-1:0] qx;
        logic [PW-1:0] qy;
        logic [DW-1:0] den;
        logic          sx_neg;
        logic          sy_neg;
        logic signed [31:0] depth;
        logic          behind;
    } div_t;

    logic [L-1:0] v_reg;
    logic         adv;
    div_t         st_reg [NS+1];
    div_t         st_next [NS];
    vrp_pkg::screen_t out_reg;

    logic [44:0] mx, my;
    logic signed [47:0] offx, offy;
    logic [PW-1:0] magx, magy;
    logic signed [47:0] svx, svy;

    assign adv       = !v_reg[L-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[L-1];
    assign out_data  = out_reg;

    always_comb
    begin
        mx = 45'(in_data.px[31] ? 33'(-33'(in_data.px)) : 33'(in_data.px)) * 45'(cfg.view_height);
        my = 45'(in_data.py_mag) * 45'(cfg.view_height);
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_div
        always_comb
        begin
            logic [DW:0] tx, ty;
            st_next[i] = st_reg[i];
            tx = {st_reg[i].rx[DW-1:0], st_reg[i].nx[PW-1]};
            ty = {st_reg[i].ry[DW-1:0], st_reg[i].ny[PW-1]};
            st_next[i].nx = st_reg[i].nx << 1;
            st_next[i].ny = st_reg[i].ny << 1;
            if (tx >= {1'b0, st_reg[i].den})
            begin
                st_next[i].rx = tx - {1'b0, st_reg[i].den};
                st_next[i].qx = {st_reg[i].qx[PW-2:0], 1'b1};
            end
            else
            begin
                st_next[i].rx = tx;
                st_next[i].qx = {st_reg[i].qx[PW-2:0], 1'b0};
            end
            if (ty >= {1'b0, st_reg[i].den})
            begin
                st_next[i].ry = ty - {1'b0, st_reg[i].den};
                st_next[i].qy = {st_reg[i].qy[PW-2:0], 1'b1};
            end
            else
            begin
                st_next[i].ry = ty;
                st_next[i].qy = {st_reg[i].qy[PW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                st_reg[i+1] <= st_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0].nx     <= {mx, F'(0)};
            st_reg[0].ny     <= {my, F'(0)};
            st_reg[0].rx     <= '0;
            st_reg[0].ry     <= '0;
            st_reg[0].qx     <= '0;
            st_reg[0].qy     <= '0;
            st_reg[0].den    <= {in_data.depth[31:0], 1'b0};
            st_reg[0].sx_neg <= in_data.px[31];
            st_reg[0].sy_neg <= in_data.py_neg;
            st_reg[0].depth  <= in_data.depth;
            st_reg[0].behind <= in_data.behind;
        end
    end

    always_comb
    begin
        offx = 48'(signed'({1'b0, cfg.view_width})) <<< (F - 1);
        offy = 48'(signed'({1'b0, cfg.view_height})) <<< (F - 1);
        magx = (st_reg[NS].qx >= (PW'(1) << 40)) ? (PW'(1) << 40) : st_reg[NS].qx;
        magy = (st_reg[NS].qy >= (PW'(1) << 40)) ? (PW'(1) << 40) : st_reg[NS].qy;
        svx  = st_reg[NS].sx_neg ? -48'(magx) : 48'(magx);
        svy  = st_reg[NS].sy_neg ? -48'(magy) : 48'(magy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[L-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.view_depth    <= st_reg[NS].depth;
            out_reg.behind_viewer <= st_reg[NS].behind;
            out_reg.screen_x <= st_reg[NS].behind ? 32'sd0 : vrp_pkg::sat32(svx + offx);
            out_reg.screen_y <= st_reg[NS].behind ? 32'sd0 : vrp_pkg::sat32(svy + offy);
        end
    end

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.behind_viewer |-> out_data.screen_x == 32'sd0
            && out_data.screen_y == 32'sd0)
        else $error("behind vertex has nonzero screen position");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.behind_viewer == (out_data.view_depth <= 32'sd0))
        else $error("behind flag disagrees with depth");
endmodule
`default_nettype wire

@@ design/vertex_rotate_project.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Perspective vertex transform.
// vin carries model_x/y/z (signed Q16.16); vout carries screen_x, screen_y,
// view_depth and behind_viewer. Registers (cos, sin, width, height, depth
// offset) are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while idle, which the block itself does not enforce.
// Throughput: one vertex per clock while vout.ready stays high. Data passes
// through 4 rotation stages, the queue, then the bit-per-stage projection
// divider and output register; the divider stage count sets the latency.
// Reset empties every pipeline and the queue and loads register defaults.
// When the receiver stalls, the back pipeline freezes, the queue fills,
// then the front freezes and vin.ready falls; nothing is dropped.
// Depth <= 0 sets behind_viewer and forces screen_x/y to zero.
module vertex_rotate_project #(
    parameter int COORD_FRAC_BITS = vrp_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    vrp_stream_if.sink                           vin,
    vrp_stream_if.source                         vout,
    input  wire logic                            cfg_we,
    input  wire logic [vrp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [vrp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    vrp_pkg::cfg_t     cfg_reg;
    vrp_pkg::rotated_t f_data, q_data;
    logic f_valid, f_ready, q_valid, q_ready;
    vrp_pkg::screen_t  b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_angle    <= vrp_pkg::COS_RESET;
            cfg_reg.sin_angle    <= vrp_pkg::SIN_RESET;
            cfg_reg.view_width   <= vrp_pkg::WIDTH_RESET;
            cfg_reg.view_height  <= vrp_pkg::HEIGHT_RESET;
            cfg_reg.depth_offset <= vrp_pkg::DOFS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vrp_pkg::REG_COS:    cfg_reg.cos_angle    <= cfg_data[15:0];
                vrp_pkg::REG_SIN:    cfg_reg.sin_angle    <= cfg_data[15:0];
                vrp_pkg::REG_WIDTH:  cfg_reg.view_width   <= cfg_data[12:0];
                vrp_pkg::REG_HEIGHT: cfg_reg.view_height  <= cfg_data[12:0];
                vrp_pkg::REG_DOFS:   cfg_reg.depth_offset <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    vrp_front u_front (
        .clk, .rst_n, .cfg(cfg_reg),
        .in_valid(vin.valid), .in_ready(vin.ready), .in_data(vin.data),
        .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
    );

    vrp_fifo #(.W($bits(vrp_pkg::rotated_t))) u_fifo (
        .clk, .rst_n,
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    vrp_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
        .clk, .rst_n, .cfg(cfg_reg),
        .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
        .out_valid(vout.valid), .out_ready(vout.ready), .out_data(b_data)
    );

    assign vout.data = b_data;
endmodule
`default_nettype wire

@@ test/tb_vertex_rotate_project.sv @@
`timescale 1ns / 1ps
module tb_vertex_rotate_project;

    localparam int FRAC = vrp_pkg::COORD_FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES = 120;
    localparam int RECV_HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [vrp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [vrp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    vrp_stream_if #(.W($bits(vrp_pkg::vertex_t))) vin ();
    vrp_stream_if #(.W($bits(vrp_pkg::screen_t))) vout ();

    vertex_rotate_project DUT (
        .clk(clk), .rst_n(rst_n), .vin(vin), .vout(vout),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the registers
    logic signed [15:0] m_cos = vrp_pkg::COS_RESET;
    logic signed [15:0] m_sin = vrp_pkg::SIN_RESET;
    logic [12:0] m_width = vrp_pkg::WIDTH_RESET;
    logic [12:0] m_height = vrp_pkg::HEIGHT_RESET;
    logic [30:0] m_dofs = vrp_pkg::DOFS_RESET;

    vrp_pkg::vertex_t pending_vertices[$];
    vrp_pkg::screen_t expected_screens[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    logic hold_start = 1'b0;
    logic recv_hold;
    int mismatches = 0;
    int vertices_sent = 0;
    int screens_seen = 0;
    int behind_seen = 0;

    assign recv_hold = hold_left != 0;

    // long receiver hold, counted here
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= RECV_HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_mac(longint a, longint p, longint b, longint q);
        longint acc;
        acc = a * p + b * q + 64'sd8192;
        return clamp32(acc >>> 14);
    endfunction

    function automatic longint project_axis(longint v, longint h, longint z, longint off);
        longint unsigned mag_in, num, den, quo, rem, mag;
        longint sv;
        mag_in = (v < 0) ? -v : v;
        num = mag_in * h;
        den = 2 * z;
        quo = num / den;
        rem = num % den;
        if (quo >= (64'd1 << (40 - FRAC)))
            mag = 64'd1 << 40;
        else
            mag = (quo << FRAC) + ((rem << FRAC) / den);
        sv = (v < 0) ? -longint'(mag) : longint'(mag);
        return clamp32(sv + off);
    endfunction

    function automatic vrp_pkg::screen_t transform_vertex(vrp_pkg::vertex_t vx);
        vrp_pkg::screen_t r;
        longint x, y, z, c, s, y1, z1, x2, z2, d;
        x = vx.model_x; y = vx.model_y; z = vx.model_z;
        c = m_cos; s = m_sin;
        y1 = round_mac(y, c, z, -s);
        z1 = round_mac(y, s, z, c);
        x2 = round_mac(x, c, z1, s);
        z2 = round_mac(z1, c, x, -s);
        d = clamp32(z2 + longint'(m_dofs));
        r = '0;
        r.view_depth = d[31:0];
        if (d <= 0)
            r.behind_viewer = 1'b1;
        else
        begin
            r.screen_x = 32'(project_axis(x2, m_height, d, longint'(m_width) << (FRAC - 1)));
            r.screen_y = 32'(project_axis(-y1, m_height, d,
                                          longint'(m_height) << (FRAC - 1)));
        end
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vin.valid <= 1'b0;
            vin.data <= '0;
        end
        else
        begin
            if (!vin.valid || vin.ready)
            begin
                if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    vin.valid <= 1'b1;
                    vin.data <= pending_vertices[0];
                    expected_screens.push_back(transform_vertex(pending_vertices[0]));
                    void'(pending_vertices.pop_front());
                    vertices_sent++;
                end
                else
                    vin.valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        vrp_pkg::screen_t got, exp_s;
        if (!rst_n)
            vout.ready <= 1'b0;
        else
        begin
            if (vout.valid && vout.ready)
            begin
                got = vout.data;
                screens_seen++;
                if (got.behind_viewer) behind_seen++;
                if (expected_screens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %h", got);
                end
                else
                begin
                    exp_s = expected_screens.pop_front();
                    if (got !== exp_s)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch sx %h/%h sy %h/%h d %h/%h b %b/%b",
                                exp_s.screen_x, got.screen_x, exp_s.screen_y,
                                got.screen_y, exp_s.view_depth, got.view_depth,
                                exp_s.behind_viewer, got.behind_viewer);
                    end
                end
            end
            vout.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_vertices.size() > 0 || expected_screens.size() > 0)
            @(posedge clk);
        wait_cycles(4);
    endtask

    task automatic write_reg(logic [vrp_pkg::CFG_INDEX_W-1:0] idx,
                             logic [vrp_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            vrp_pkg::REG_COS: m_cos = val[15:0];
            vrp_pkg::REG_SIN: m_sin = val[15:0];
            vrp_pkg::REG_WIDTH: m_width = val[12:0];
            vrp_pkg::REG_HEIGHT: m_height = val[12:0];
            vrp_pkg::REG_DOFS: m_dofs = val[30:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 40 << FRAC)) - (20 << FRAC));
            2: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
            default: return 32'($signed($urandom_range(0, 4 << FRAC)) - (2 << FRAC));
        endcase
    endfunction

    task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vrp_pkg::vertex_t v;
        v.model_x = x; v.model_y = y; v.model_z = z;
        pending_vertices.push_back(v);
    endtask

    task automatic add_random(int n);
        repeat (n) add_vertex(rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic random_config(int phase);
        int unsigned ang;
        ang = $urandom_range(32768);
        case (phase % 4)
            0:
            begin
                write_reg(vrp_pkg::REG_COS, 16'sh4000);
                write_reg(vrp_pkg::REG_SIN, 16'sh0);
            end
            1:
            begin
                write_reg(vrp_pkg::REG_COS, -16'sh4000);
                write_reg(vrp_pkg::REG_SIN, 16'sh4000);
            end
            2:
            begin
                write_reg(vrp_pkg::REG_COS, 16'sh0);
                write_reg(vrp_pkg::REG_SIN, -16'sh4000);
            end
            default:
            begin
                write_reg(vrp_pkg::REG_COS, vrp_pkg::CFG_DATA_W'(16'(int'(ang) - 16384)));
                write_reg(vrp_pkg::REG_SIN,
                          vrp_pkg::CFG_DATA_W'(16'($urandom_range(32768) - 16384)));
            end
        endcase
        write_reg(vrp_pkg::REG_WIDTH, (phase % 3 == 0) ? 13'd4096 :
                  vrp_pkg::CFG_DATA_W'($urandom_range(1, 4096)));
        write_reg(vrp_pkg::REG_HEIGHT, (phase % 3 == 1) ? 13'd1 :
                  vrp_pkg::CFG_DATA_W'($urandom_range(1, 4096)));
        case (phase % 3)
            0: write_reg(vrp_pkg::REG_DOFS, 31'h7FFF_FFFF);
            1: write_reg(vrp_pkg::REG_DOFS, 31'd0);
            default: write_reg(vrp_pkg::REG_DOFS,
                               vrp_pkg::CFG_DATA_W'($urandom_range(0, 200 << FRAC)));
        endcase
    endtask

    initial
    begin
        wait_cycles(7);
        rst_n <= 1'b1;
        wait_cycles(2);

        // directed: reset config, extremes, depth zero/negative, rounding ties
        add_vertex(0, 0, 0);
        add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0);
        add_vertex(1 << FRAC, -(1 << FRAC), 32'hFFAB_0000);     // depth exactly zero
        add_vertex(1 << FRAC, 1 << FRAC, 32'hFFAA_0000);        // just behind
        add_vertex(32'hFFFF_FFFF, 1, 32'hFFAB_0001);            // depth one LSB
        add_vertex(32'h0100_0000, 32'hFF00_0000, 32'hFFAB_0001);
        add_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
        wait_drained();
        write_reg(vrp_pkg::REG_COS, 16'sh2D41);
        write_reg(vrp_pkg::REG_SIN, 16'sh2D41);
        write_reg(3'd7, 31'h7FFF_FFFF);                         // unused index
        add_vertex(32'h0000_2001, 32'hFFFF_DFFF, 32'h0000_6000);
        add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(vrp_pkg::REG_WIDTH, 13'd1);
        write_reg(vrp_pkg::REG_HEIGHT, 13'd4096);
        write_reg(vrp_pkg::REG_DOFS, 31'd1);
        add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1 << FRAC);
        add_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
        add_vertex(0, 0, 0);
        add_vertex(32'h4000_0000, 32'hC000_0000, 32'h0000_1000);
        wait_drained();

        // random phases with three idle profiles
        for (int phase = 0; phase < 12; phase++)
        begin
            send_idle_pct = (phase < 4) ? 12 : (phase < 8) ? 58 : 0;
            recv_idle_pct = (phase < 4) ? 58 : (phase < 8) ? 12 : 0;
            random_config(phase);
            if (phase == 9)
            begin
                // long receiver stall while the sender keeps offering
                hold_start <= 1'b1;
                add_random(140);
                @(posedge clk);
                hold_start <= 1'b0;
            end
            else
                add_random(60);
            wait_drained();
        end

        wait_cycles(DRAIN_CYCLES);
        $display("Transformed %0d vertices (%0d behind viewer) over 12 random register settings.",
            screens_seen, behind_seen);
        $display("Covered coordinate extremes, rounding ties, saturation and stalls.");
        if (mismatches == 0 && expected_screens.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
